// ===== rtl/pidds_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, status codes and item types for the
// positional PID controller with dead zone and integral separation.
// ----------------------------------------------------------------------------
package pidds_pkg;

	// Word format: signed fixed point, Q16.16.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;

	// Limits are magnitudes, one bit narrower than the word.
	localparam int LIMIT_WIDTH = DATA_WIDTH - 1;
	// Separation limit is a whole-unit integer.
	localparam int SEP_WIDTH = DATA_WIDTH - FRAC_BITS;

	localparam int CFG_INDEX_WIDTH = 3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_CLAMP = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEAD_ZONE = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_CUTOFF = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEPARATION_LIMIT = 3'd7;

	// Result status codes.
	localparam int STATUS_WIDTH = 2;
	localparam logic [STATUS_WIDTH-1:0] STATUS_NORMAL = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_CUTOFF = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_DEAD_ZONE = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] measured;
		logic signed [DATA_WIDTH-1:0] target;
	} meas_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive;
		logic [STATUS_WIDTH-1:0] status;
	} ctrl_t;

endpackage

// ===== rtl/pid_with_deadband_and_separation.sv =====
// ----------------------------------------------------------------------------
// Positional PID controller with dead zone and integral separation
// Five-stage pipeline computing one saturated Q16.16 PID step per item.
// ----------------------------------------------------------------------------
// The controller takes one measurement/target item per clock and returns one
// drive/status item for each, in order. A result appears on ctrl from the
// stage 5 result register, and while ctrl is not stalled the sustained rate
// is one item per cycle. Two pieces of state close a loop from one item to
// the next: the previous error is updated in stage 1 and the integrator in
// stage 3, each as its item moves on, so back-to-back items see exactly the
// state their predecessor left. Stages collapse bubbles on their own, so the
// input keeps accepting while a result waits on a stalled output, until every
// stage is full. Configuration registers take effect immediately and must
// only be written when no item is in flight. The error is target minus
// measured; an error over the cutoff gives status 1, one inside the dead zone
// gives status 2, both with zero drive and no change to the controller state.
module pid_with_deadband_and_separation (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       meas_valid,
	output logic                                       meas_stall,
	input  pidds_pkg::meas_t                           meas,
	output logic                                       ctrl_valid,
	input  logic                                       ctrl_stall,
	output pidds_pkg::ctrl_t                           ctrl,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [pidds_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
	input  logic [pidds_pkg::DATA_WIDTH-1:0]           cfg_data
);
	import pidds_pkg::*;

	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Saturate a sum that grew by one bit back into the word range.
	function automatic word_t sat_word(input logic [DATA_WIDTH:0] v);
		if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
			return v[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	// Drop the fraction bits of a full product (floor) and saturate.
	function automatic word_t scale_product(input logic signed [PROD_WIDTH-1:0] prod);
		logic signed [PROD_WIDTH-1:0] shifted;
		logic [PROD_WIDTH-DATA_WIDTH:0] upper;
		shifted = prod >>> FRAC_BITS;
		upper = shifted[PROD_WIDTH-1:DATA_WIDTH-1];
		if (!((&upper) || !(|upper))) begin
			return shifted[PROD_WIDTH-1] ? WORD_MIN : WORD_MAX;
		end
		return shifted[DATA_WIDTH-1:0];
	endfunction

	// Symmetric clamp to plus or minus a magnitude limit.
	function automatic word_t clamp_sym(input word_t v, input logic [LIMIT_WIDTH-1:0] lim);
		logic signed [DATA_WIDTH:0] v_x;
		logic signed [DATA_WIDTH:0] lim_x;
		logic signed [DATA_WIDTH:0] neg_x;
		v_x = {v[DATA_WIDTH-1], v};
		lim_x = {2'b00, lim};
		neg_x = -lim_x;
		if (v_x > lim_x) begin
			return {1'b0, lim};
		end
		if (v_x < neg_x) begin
			return neg_x[DATA_WIDTH-1:0];
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LIMIT_WIDTH-1:0] output_limit_q;
	logic [LIMIT_WIDTH-1:0] integral_clamp_q;
	logic [LIMIT_WIDTH-1:0] dead_zone_q;
	logic [LIMIT_WIDTH-1:0] error_cutoff_q;
	word_t                  gain_p_q;
	word_t                  gain_i_q;
	word_t                  gain_d_q;
	logic [SEP_WIDTH-1:0]   separation_limit_q;

	// The register file never holds off a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= '0;
			integral_clamp_q <= '0;
			dead_zone_q <= '0;
			error_cutoff_q <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			separation_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OUTPUT_LIMIT: begin
					output_limit_q <= cfg_data[LIMIT_WIDTH-1:0];
				end
				REG_INTEGRAL_CLAMP: begin
					integral_clamp_q <= cfg_data[LIMIT_WIDTH-1:0];
				end
				REG_DEAD_ZONE: begin
					dead_zone_q <= cfg_data[LIMIT_WIDTH-1:0];
				end
				REG_ERROR_CUTOFF: begin
					error_cutoff_q <= cfg_data[LIMIT_WIDTH-1:0];
				end
				REG_GAIN_P: begin
					gain_p_q <= cfg_data;
				end
				REG_GAIN_I: begin
					gain_i_q <= cfg_data;
				end
				REG_GAIN_D: begin
					gain_d_q <= cfg_data;
				end
				REG_SEPARATION_LIMIT: begin
					separation_limit_q <= cfg_data[SEP_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage takes a new item when it is empty
	// or when its contents move on in the same cycle.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	assign ready_s5 = !valid_s5 || !ctrl_stall;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign meas_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= meas_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register, error, window checks and error difference
	// ------------------------------------------------------------------
	meas_t meas_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && meas_valid) begin
			meas_s1 <= meas;
		end
	end

	word_t                  err_c;
	logic [DATA_WIDTH-1:0]  abs_err_c;
	logic [STATUS_WIDTH-1:0] status_c;
	word_t                  err_diff_c;
	word_t                  prev_err_q;

	always_comb begin
		err_c = sat_word({meas_s1.target[DATA_WIDTH-1], meas_s1.target}
			- {meas_s1.measured[DATA_WIDTH-1], meas_s1.measured});
		// The most negative error has a magnitude that still fits unsigned.
		abs_err_c = err_c[DATA_WIDTH-1] ? (~err_c + 1'b1) : err_c;
		// The cutoff wins over the dead zone.
		if ((error_cutoff_q != '0) && (abs_err_c > {1'b0, error_cutoff_q})) begin
			status_c = STATUS_CUTOFF;
		end else if ((dead_zone_q != '0) && (abs_err_c < {1'b0, dead_zone_q})) begin
			status_c = STATUS_DEAD_ZONE;
		end else begin
			status_c = STATUS_NORMAL;
		end
		err_diff_c = sat_word({err_c[DATA_WIDTH-1], err_c} - {prev_err_q[DATA_WIDTH-1], prev_err_q});
	end

	// The previous error follows only items that go through the controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (valid_s1 && ready_s2 && (status_c == STATUS_NORMAL)) begin
			prev_err_q <= err_c;
		end
	end

	word_t                   err_s2;
	word_t                   err_diff_s2;
	logic [DATA_WIDTH-1:0]   abs_err_s2;
	logic [STATUS_WIDTH-1:0] status_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			err_s2 <= err_c;
			err_diff_s2 <= err_diff_c;
			abs_err_s2 <= abs_err_c;
			status_s2 <= status_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the separation check and the three gain multiplies, run side by side
	// ------------------------------------------------------------------
	logic signed [PROD_WIDTH-1:0] prod_p_c;
	logic signed [PROD_WIDTH-1:0] prod_i_c;
	logic signed [PROD_WIDTH-1:0] prod_d_c;
	logic                         sep_hit_c;

	always_comb begin
		prod_p_c = gain_p_q * err_s2;
		prod_i_c = gain_i_q * err_s2;
		prod_d_c = gain_d_q * err_diff_s2;
		// Separation limit is in whole units, so align it to the error.
		sep_hit_c = (separation_limit_q != '0)
			&& (abs_err_s2 > {separation_limit_q, {FRAC_BITS{1'b0}}});
	end

	word_t                   term_p_s3;
	word_t                   term_i_s3;
	word_t                   term_d_s3;
	logic                    sep_hit_s3;
	logic [STATUS_WIDTH-1:0] status_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			term_p_s3 <= scale_product(prod_p_c);
			term_i_s3 <= scale_product(prod_i_c);
			term_d_s3 <= scale_product(prod_d_c);
			sep_hit_s3 <= sep_hit_c;
			status_s3 <= status_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: integrator update, separation and clamp
	// ------------------------------------------------------------------
	word_t integ_q;
	word_t integ_sum_c;
	word_t integ_next_c;

	always_comb begin
		if (sep_hit_s3) begin
			integ_sum_c = '0;
		end else begin
			integ_sum_c = sat_word({integ_q[DATA_WIDTH-1], integ_q}
				+ {term_i_s3[DATA_WIDTH-1], term_i_s3});
		end
		integ_next_c = clamp_sym(integ_sum_c, integral_clamp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (valid_s3 && ready_s4 && (status_s3 == STATUS_NORMAL)) begin
			integ_q <= integ_next_c;
		end
	end

	word_t                   term_p_s4;
	word_t                   term_i_s4;
	word_t                   term_d_s4;
	logic [STATUS_WIDTH-1:0] status_s4;

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			term_p_s4 <= term_p_s3;
			term_i_s4 <= integ_next_c;
			term_d_s4 <= term_d_s3;
			status_s4 <= status_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: sum of the three terms, zero drive for skipped items and output clamp
	// ------------------------------------------------------------------
	word_t sum_pi_c;
	word_t sum_pid_c;
	word_t drive_c;

	always_comb begin
		sum_pi_c = sat_word({term_p_s4[DATA_WIDTH-1], term_p_s4}
			+ {term_i_s4[DATA_WIDTH-1], term_i_s4});
		sum_pid_c = sat_word({sum_pi_c[DATA_WIDTH-1], sum_pi_c}
			+ {term_d_s4[DATA_WIDTH-1], term_d_s4});
		if (status_s4 != STATUS_NORMAL) begin
			drive_c = '0;
		end else begin
			drive_c = clamp_sym(sum_pid_c, output_limit_q);
		end
	end

	// Stage 5 is the result register.
	ctrl_t ctrl_s5;

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			ctrl_s5.drive <= drive_c;
			ctrl_s5.status <= status_s4;
		end
	end

	assign ctrl_valid = valid_s5;
	assign ctrl = ctrl_s5;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// An item that skips the controller leaves the integrator alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ready_s4 && (status_s3 != STATUS_NORMAL)) |=> $stable(integ_q))
		else $error("integrator changed on a skipped item");

	// An item that skips the controller leaves the previous error alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2 && (status_c != STATUS_NORMAL)) |=> $stable(prev_err_q))
		else $error("previous error changed on a skipped item");

	// Skipped items always carry a zero drive.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_valid && (ctrl.status != STATUS_NORMAL)) |-> (ctrl.drive == '0))
		else $error("nonzero drive on a skipped item");

	// The input is held off only when every stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		meas_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled with an empty stage");

	// The unused status code never reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_valid |-> ((ctrl.status == STATUS_NORMAL) || (ctrl.status == STATUS_CUTOFF)
			|| (ctrl.status == STATUS_DEAD_ZONE)))
		else $error("illegal status code on output");

endmodule
